// File: src/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_core.
package jsu_pkg;

  // Most results that one text byte can cause (three UTF-8 bytes plus end marker)
  localparam int RES_MAX = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_QUOTE = 2'd1,
    KIND_EOT   = 2'd2
  } kind_t;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // All results of one text byte, as one queue entry
  typedef struct packed {
    logic [2:0]              cnt;
    res_t [RES_MAX-1:0]      res;
  } list_t;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Control bytes that the escapes stand for
  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

  // UTF-8 encoding limits and lead/continuation marks
  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_MASK  = 8'h3F;

endpackage

// File: src/jsu_front.sv
// Unescaper front end: string/escape/\u decoding, one byte step a cycle unless
// q_full. Replays the held \u bytes when text ends early. Depends on jsu_pkg.
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  input  logic              in_push,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output jsu_pkg::list_t    q_data
);

  typedef enum logic [3:0] {
    MODE_OUT = 4'b0001,
    MODE_IN  = 4'b0010,
    MODE_ESC = 4'b0100,
    MODE_HEX = 4'b1000
  } mode_t;

  mode_t        mode_r, mode_nxt;
  logic [1:0]   hc_r, hc_nxt;
  logic [15:0]  cp_r, cp_nxt;
  logic         stop_r, stop_nxt;
  logic [7:0]   held_r [3];

  // replay of a cut-short \u group
  logic         replay_r;
  logic [7:0]   rq_r [3];
  logic [1:0]   rq_len_r;
  logic [1:0]   rq_idx_r;

  // results gathered over the replay steps
  logic [2:0]     acc_cnt_r;
  jsu_pkg::res_t  acc_res_r [jsu_pkg::RES_MAX];

  logic           step_en;
  logic [7:0]     b;
  logic           st_last;
  logic           restart;
  logic           held_we;
  logic           keep_acc;
  logic           hex_ok;
  logic [3:0]     hex_dig;
  logic [15:0]    cp_acc;
  logic [7:0]     esc_b;
  logic [2:0]     st_cnt;
  jsu_pkg::res_t  st_res [jsu_pkg::RES_MAX];
  logic [2:0]     mg_cnt;
  jsu_pkg::res_t  mg_res [jsu_pkg::RES_MAX];

  // input is held off while the queue is full or a replay runs
  assign in_full = q_full || replay_r;
  assign step_en = (replay_r || in_push) && !q_full;

  // byte of this step and whether it is the last of the text
  assign b       = replay_r ? rq_r[rq_idx_r] : in_text_byte;
  assign st_last = replay_r ? (rq_idx_r == (rq_len_r - 2'd1)) : in_end_of_text;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_dig = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      hex_dig = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      hex_dig = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_acc = (!stop_r && hex_ok) ? {cp_r[11:0], hex_dig} : cp_r;

  // escape letter to byte
  always_comb begin
    case (b)
      jsu_pkg::CH_B: esc_b = jsu_pkg::CTRL_BS;
      jsu_pkg::CH_F: esc_b = jsu_pkg::CTRL_FF;
      jsu_pkg::CH_N: esc_b = jsu_pkg::CTRL_LF;
      jsu_pkg::CH_R: esc_b = jsu_pkg::CTRL_CR;
      jsu_pkg::CH_T: esc_b = jsu_pkg::CTRL_HT;
      default:       esc_b = b;
    endcase
  end

  // one decode step
  always_comb begin
    mode_nxt = mode_r;
    hc_nxt   = hc_r;
    cp_nxt   = cp_r;
    stop_nxt = stop_r;
    held_we  = 1'b0;
    restart  = 1'b0;
    st_cnt   = 3'd0;
    for (int k = 0; k < jsu_pkg::RES_MAX; k++) begin
      st_res[k] = '{data: 8'h00, kind: jsu_pkg::KIND_BYTE};
    end
    case (mode_r)
      MODE_OUT: begin
        if (b == jsu_pkg::CH_QUOTE) mode_nxt = MODE_IN;
      end
      MODE_IN: begin
        if (b == jsu_pkg::CH_QUOTE) begin
          st_res[0] = '{data: 8'h00, kind: jsu_pkg::KIND_QUOTE};
          st_cnt    = 3'd1;
          mode_nxt  = MODE_OUT;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          if (st_last) begin
            st_res[0] = '{data: b, kind: jsu_pkg::KIND_BYTE};
            st_cnt    = 3'd1;
          end else begin
            mode_nxt = MODE_ESC;
          end
        end else begin
          st_res[0] = '{data: b, kind: jsu_pkg::KIND_BYTE};
          st_cnt    = 3'd1;
        end
      end
      MODE_ESC: begin
        if (b == jsu_pkg::CH_U) begin
          mode_nxt = MODE_HEX;
          hc_nxt   = 2'd0;
          cp_nxt   = 16'h0000;
          stop_nxt = 1'b0;
        end else begin
          st_res[0] = '{data: esc_b, kind: jsu_pkg::KIND_BYTE};
          st_cnt    = 3'd1;
          mode_nxt  = MODE_IN;
        end
      end
      MODE_HEX: begin
        cp_nxt   = cp_acc;
        stop_nxt = stop_r || !hex_ok;
        if (hc_r == 2'd3) begin
          // code point to UTF-8
          if (cp_acc <= jsu_pkg::UTF8_MAX1) begin
            st_res[0] = '{data: cp_acc[7:0], kind: jsu_pkg::KIND_BYTE};
            st_cnt    = 3'd1;
          end else if (cp_acc <= jsu_pkg::UTF8_MAX2) begin
            st_res[0] = '{data: jsu_pkg::UTF8_LEAD2 | {3'b000, cp_acc[10:6]},
                          kind: jsu_pkg::KIND_BYTE};
            st_res[1] = '{data: jsu_pkg::UTF8_CONT | ({2'b00, cp_acc[5:0]} & jsu_pkg::UTF8_MASK),
                          kind: jsu_pkg::KIND_BYTE};
            st_cnt    = 3'd2;
          end else begin
            st_res[0] = '{data: jsu_pkg::UTF8_LEAD3 | {4'h0, cp_acc[15:12]},
                          kind: jsu_pkg::KIND_BYTE};
            st_res[1] = '{data: jsu_pkg::UTF8_CONT | ({2'b00, cp_acc[11:6]} & jsu_pkg::UTF8_MASK),
                          kind: jsu_pkg::KIND_BYTE};
            st_res[2] = '{data: jsu_pkg::UTF8_CONT | ({2'b00, cp_acc[5:0]} & jsu_pkg::UTF8_MASK),
                          kind: jsu_pkg::KIND_BYTE};
            st_cnt    = 3'd3;
          end
          mode_nxt = MODE_IN;
          hc_nxt   = 2'd0;
        end else if (st_last) begin
          restart = 1'b1;
        end else begin
          held_we = 1'b1;
          hc_nxt  = hc_r + 2'd1;
        end
      end
      default: mode_nxt = MODE_OUT;
    endcase

    // end of text closes everything
    if (st_last && !restart) begin
      if (mode_nxt != MODE_OUT) begin
        st_res[st_cnt[1:0]] = '{data: 8'h00, kind: jsu_pkg::KIND_EOT};
        st_cnt              = st_cnt + 3'd1;
      end
      mode_nxt = MODE_OUT;
      hc_nxt   = 2'd0;
      cp_nxt   = 16'h0000;
      stop_nxt = 1'b0;
    end

    // short \u group: start over inside the string on the held bytes
    if (restart) begin
      mode_nxt = MODE_IN;
      hc_nxt   = 2'd0;
      cp_nxt   = 16'h0000;
      stop_nxt = 1'b0;
    end
  end

  // append this step's results to those gathered so far
  always_comb begin
    for (int k = 0; k < jsu_pkg::RES_MAX; k++) begin
      if (3'(k) < acc_cnt_r) begin
        mg_res[k] = acc_res_r[k];
      end else begin
        mg_res[k] = st_res[2'(k) - acc_cnt_r[1:0]];
      end
    end
    mg_cnt = acc_cnt_r + st_cnt;
  end

  assign keep_acc = restart || (replay_r && !st_last);
  assign q_push   = step_en && !keep_acc && (mg_cnt != 3'd0);

  always_comb begin
    q_data.cnt = mg_cnt;
    for (int k = 0; k < jsu_pkg::RES_MAX; k++) begin
      q_data.res[k] = mg_res[k];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OUT;
      hc_r      <= 2'd0;
      cp_r      <= 16'h0000;
      stop_r    <= 1'b0;
      replay_r  <= 1'b0;
      rq_len_r  <= 2'd0;
      rq_idx_r  <= 2'd0;
      acc_cnt_r <= 3'd0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      hc_r      <= hc_nxt;
      cp_r      <= cp_nxt;
      stop_r    <= stop_nxt;
      acc_cnt_r <= keep_acc ? mg_cnt : 3'd0;
      if (restart) begin
        replay_r <= 1'b1;
        rq_idx_r <= 2'd0;
        rq_len_r <= hc_r + 2'd1;
      end else if (replay_r) begin
        if (st_last) replay_r <= 1'b0;
        else         rq_idx_r <= rq_idx_r + 2'd1;
      end
    end
  end

  // held bytes, replay bytes and gathered results
  always_ff @(posedge clk) begin
    if (step_en) begin
      if (held_we) held_r[hc_r] <= b;
      if (restart) begin
        for (int k = 0; k < 3; k++) begin
          rq_r[k] <= (2'(k) == hc_r) ? b : held_r[k];
        end
      end
      for (int k = 0; k < jsu_pkg::RES_MAX; k++) begin
        acc_res_r[k] <= mg_res[k];
      end
    end
  end

endmodule

// File: src/jsu_queue.sv
// Short queue of result lists between front and back end.
// Depends on jsu_pkg for the entry type.
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jsu_pkg::list_t  push_data,
  output logic            full,
  input  logic            pop,
  output jsu_pkg::list_t  pop_data,
  output logic            empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::list_t   mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: src/jsu_back.sv
// Back end: walks each queued result list and presents one beat at a time
// from an output register. Depends on jsu_pkg.
module jsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::list_t  q_data,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_run_last
);

  logic          valid_r;
  logic [7:0]    byte_r;
  logic [1:0]    kind_r;
  logic          last_r;
  logic [1:0]    idx_r;
  logic          load;
  logic          take;
  logic          at_end;
  jsu_pkg::res_t cur;

  // output register refills when empty or being taken
  assign load   = !valid_r || out_pop;
  assign take   = load && !q_empty;
  assign cur    = q_data.res[idx_r];
  assign at_end = (({1'b0, idx_r} + 3'd1) == q_data.cnt);
  assign q_pop  = take && at_end;

  assign out_empty    = !valid_r;
  assign out_byte     = byte_r;
  assign out_kind     = kind_r;
  assign out_run_last = last_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= !q_empty;
      if (take) idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= cur.data;
      kind_r <= cur.kind;
      last_r <= at_end;
    end
  end

endmodule

// File: src/json_string_unescape_core.sv
// JSON string unescaper. Results pass a burst-absorbing queue, then the output register.
// Throughput: one text byte per cycle while in_full is low; a byte with several results drains
// at one beat per cycle while out_pop is high, set by the single output register.
// A short \u group at end of text replays its bytes one per cycle unless q_full; input waits.
// Reset (synchronous, active low) returns to outside a string with queue and output empty.
module json_string_unescape_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  input  logic       in_push,
  output logic       in_full,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_run_last,
  output logic       out_empty,
  input  logic       out_pop
);

  logic           q_push, q_full, q_pop, q_empty;
  jsu_pkg::list_t q_wdata, q_rdata;

  // decode
  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .in_push        (in_push),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  // decoupling queue
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // result beats
  jsu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_run_last (out_run_last)
  );

endmodule
